// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

    localparam int MAX_COLS  = 128;
    localparam int MAX_ROWS  = 64;
    localparam int BUF_CELLS = MAX_COLS * MAX_ROWS;

    localparam int ADDR_W    = $clog2(BUF_CELLS);
    localparam int CELLS_W   = ADDR_W + 1;
    localparam int COLS_W    = 8;
    localparam int ROWS_W    = 7;
    localparam int COL_IDX_W = 7;
    localparam int COLOR_W   = 4;
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int CELL_W    = CHAR_W + ATTR_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int DIV_CNT_W = $clog2(ADDR_W);

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

    localparam logic [COLS_W-1:0] COLS_RESET = 8'd80;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd25;
    localparam logic [COLOR_W-1:0] FG_RESET  = 4'hF;
    localparam logic [COLOR_W-1:0] BG_RESET  = 4'h0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLUMNS  = 2'd0,
        REG_ROWS     = 2'd1,
        REG_FG_COLOR = 2'd2,
        REG_BG_COLOR = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_PUT,
        S_READ,
        S_COPY,
        S_BLANK,
        S_DONE
    } t_state;

endpackage

// ===== rtl/tcw_in_if.sv =====
interface tcw_in_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [tcw_pkg::CHAR_W-1:0]   char_code;
    logic [tcw_pkg::ADDR_W-1:0]   cell_index;

    modport source (output valid, action, char_code, cell_index, input ready);
    modport sink   (input valid, action, char_code, cell_index, output ready);
endinterface

// ===== rtl/tcw_out_if.sv =====
interface tcw_out_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::ADDR_W-1:0]   cursor_position;
    logic [tcw_pkg::CHAR_W-1:0]   cell_char;
    logic [tcw_pkg::ATTR_W-1:0]   cell_attr;

    modport source (output valid, cursor_position, cell_char, cell_attr, input ready);
    modport sink   (input valid, cursor_position, cell_char, cell_attr, output ready);
endinterface

// ===== rtl/text_console_writer_top.sv =====
// Text console writer. The screen lives in one 8192 x 16 cell memory (char in the low
// byte, attribute in the high byte) with one write and one registered read port. After
// reset the block sweeps the whole memory to zero and takes no request until that is
// done (configuration writes are taken at any time). A printable byte, newline or
// carriage return goes from idle straight to the result state; a cell read first
// passes through a read state that picks up the registered read data. A put that runs
// off the last cell scrolls the screen: the copy and the blanking of the bottom row
// both go through the single write port (on a one-row screen only the blanking, as
// there is nothing to copy). After columns or rows is written, the next put first
// finds the cursor's row and column with a radix-2 divider. Results sit in an output
// register, so a new request is taken while the previous result waits.
module text_console_writer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    tcw_in_if.sink                           i_req,
    tcw_out_if.source                        o_rsp
);

    localparam int AW = tcw_pkg::ADDR_W;
    localparam int CW = tcw_pkg::CELLS_W;

    // configuration
    logic [tcw_pkg::COLS_W-1:0]  r_columns;
    logic [tcw_pkg::ROWS_W-1:0]  r_rows;
    logic [tcw_pkg::COLOR_W-1:0] r_fg;
    logic [tcw_pkg::COLOR_W-1:0] r_bg;

    // control and cursor state
    tcw_pkg::t_state              r_state, n_state;
    logic [AW-1:0]                r_cursor, n_cursor;
    logic [AW-1:0]                r_row_base, n_row_base;
    logic [tcw_pkg::COL_IDX_W-1:0] r_col, n_col;
    logic                         r_dirty, n_dirty;
    logic [CW-1:0]                r_scan, n_scan;
    logic                         r_cp_pend, n_cp_pend;
    logic [AW-1:0]                r_wr_addr, n_wr_addr;
    logic [tcw_pkg::CHAR_W-1:0]   r_req_char, n_req_char;
    logic [tcw_pkg::COLS_W-1:0]   r_div_rem, n_div_rem;
    logic [tcw_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic [AW-1:0]                r_res_cursor, n_res_cursor;
    logic [tcw_pkg::CHAR_W-1:0]   r_res_char, n_res_char;
    logic [tcw_pkg::ATTR_W-1:0]   r_res_attr, n_res_attr;
    logic                         r_out_valid, n_out_valid;
    logic [AW-1:0]                r_out_cursor, n_out_cursor;
    logic [tcw_pkg::CHAR_W-1:0]   r_out_char, n_out_char;
    logic [tcw_pkg::ATTR_W-1:0]   r_out_attr, n_out_attr;

    // screen memory
    logic [tcw_pkg::CELL_W-1:0]   mem [tcw_pkg::BUF_CELLS];
    logic [tcw_pkg::CELL_W-1:0]   r_rdata;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]   mem_wdata;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;

    // derived values
    logic [tcw_pkg::COLS_W-1:0]   eff_cols;
    logic [tcw_pkg::ROWS_W-1:0]   eff_rows;
    logic [CW-1:0]                cells;
    logic [CW-1:0]                last_row;
    logic [tcw_pkg::ATTR_W-1:0]   attr;
    logic                         accept_in;
    logic                         out_free;

    // put datapath
    logic                         put_go;
    logic [tcw_pkg::CHAR_W-1:0]   p_char;
    logic                         is_nl;
    logic                         is_cr;
    logic [CW-1:0]                nl_next;
    logic [CW-1:0]                inc;
    logic [tcw_pkg::COLS_W-1:0]   col_inc;
    logic                         scroll;
    tcw_pkg::t_state              put_state;

    // divider step
    logic [tcw_pkg::COLS_W:0]     div_shift;
    logic [tcw_pkg::COLS_W-1:0]   div_rem_next;

    assign eff_cols = (r_columns == '0) ? tcw_pkg::COLS_W'(1) :
                      (r_columns > tcw_pkg::COLS_W'(tcw_pkg::MAX_COLS)) ?
                      tcw_pkg::COLS_W'(tcw_pkg::MAX_COLS) : r_columns;
    assign eff_rows = (r_rows == '0) ? tcw_pkg::ROWS_W'(1) :
                      (r_rows > tcw_pkg::ROWS_W'(tcw_pkg::MAX_ROWS)) ?
                      tcw_pkg::ROWS_W'(tcw_pkg::MAX_ROWS) : r_rows;
    assign cells    = CW'(eff_cols) * CW'(eff_rows);
    assign last_row = cells - CW'(eff_cols);
    assign attr     = {r_bg, r_fg};

    assign i_req.ready     = (r_state == tcw_pkg::S_IDLE);
    assign accept_in       = i_req.valid && i_req.ready;
    assign out_free        = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.cursor_position = r_out_cursor;
    assign o_rsp.cell_char       = r_out_char;
    assign o_rsp.cell_attr       = r_out_attr;

    // put decode, shared by the fast path in idle and the post-divide path
    assign put_go  = (r_state == tcw_pkg::S_PUT) ||
                     (r_state == tcw_pkg::S_IDLE && accept_in && !i_req.action && !r_dirty);
    assign p_char  = (r_state == tcw_pkg::S_PUT) ? r_req_char : i_req.char_code;
    assign is_nl   = (p_char == tcw_pkg::CH_NEWLINE);
    assign is_cr   = (p_char == tcw_pkg::CH_RETURN);
    assign nl_next = {1'b0, r_row_base} + CW'(eff_cols);
    assign inc     = {1'b0, r_cursor} + CW'(1);
    assign col_inc = {1'b0, r_col} + tcw_pkg::COLS_W'(1);
    assign scroll  = is_nl ? (nl_next >= cells) : (!is_cr && inc >= cells);
    assign put_state = !scroll ? tcw_pkg::S_DONE :
                       (cells > CW'(eff_cols)) ? tcw_pkg::S_COPY : tcw_pkg::S_BLANK;

    // restoring division, one quotient bit per cycle, MSB first
    assign div_shift    = {r_div_rem, r_cursor[r_div_cnt]};
    assign div_rem_next = (div_shift >= {1'b0, eff_cols}) ?
                          tcw_pkg::COLS_W'(div_shift - {1'b0, eff_cols}) :
                          div_shift[tcw_pkg::COLS_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcw_pkg::S_CLEAR: begin
                if (r_scan == CW'(tcw_pkg::BUF_CELLS - 1)) n_state = tcw_pkg::S_IDLE;
            end
            tcw_pkg::S_IDLE: begin
                if (accept_in) begin
                    if (i_req.action)  n_state = tcw_pkg::S_READ;
                    else if (r_dirty)  n_state = tcw_pkg::S_DIV;
                    else               n_state = put_state;
                end
            end
            tcw_pkg::S_DIV: begin
                if (r_div_cnt == '0) n_state = tcw_pkg::S_PUT;
            end
            tcw_pkg::S_PUT:  n_state = put_state;
            tcw_pkg::S_READ: n_state = tcw_pkg::S_DONE;
            tcw_pkg::S_COPY: begin
                if (r_scan >= last_row) n_state = tcw_pkg::S_BLANK;
            end
            tcw_pkg::S_BLANK: begin
                if (r_scan == cells - CW'(1)) n_state = tcw_pkg::S_DONE;
            end
            tcw_pkg::S_DONE: begin
                if (out_free) n_state = tcw_pkg::S_IDLE;
            end
            default: n_state = tcw_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cursor     = r_cursor;
        n_row_base   = r_row_base;
        n_col        = r_col;
        n_dirty      = r_dirty;
        n_scan       = r_scan;
        n_cp_pend    = r_cp_pend;
        n_wr_addr    = r_wr_addr;
        n_req_char   = r_req_char;
        n_div_rem    = r_div_rem;
        n_div_cnt    = r_div_cnt;
        n_res_cursor = r_res_cursor;
        n_res_char   = r_res_char;
        n_res_attr   = r_res_attr;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_cursor = r_out_cursor;
        n_out_char   = r_out_char;
        n_out_attr   = r_out_attr;
        mem_we       = 1'b0;
        mem_waddr    = r_scan[AW-1:0];
        mem_wdata    = '0;
        rd_en        = 1'b0;
        rd_addr      = i_req.cell_index;

        if (i_cfg_we && (i_cfg_index == tcw_pkg::REG_COLUMNS ||
                         i_cfg_index == tcw_pkg::REG_ROWS)) begin
            n_dirty = 1'b1;
        end

        case (r_state)
            tcw_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_scan[AW-1:0];
                mem_wdata = '0;
                n_scan    = r_scan + CW'(1);
            end
            tcw_pkg::S_IDLE: begin
                if (accept_in) begin
                    n_req_char = i_req.char_code;
                    if (i_req.action) begin
                        rd_en   = 1'b1;
                        rd_addr = i_req.cell_index;
                    end else if (r_dirty) begin
                        // pull an off-screen cursor back to the bottom row, then divide
                        if ({1'b0, r_cursor} >= cells) n_cursor = last_row[AW-1:0];
                        n_div_rem = '0;
                        n_div_cnt = tcw_pkg::DIV_CNT_W'(AW - 1);
                    end
                end
            end
            tcw_pkg::S_DIV: begin
                n_div_rem = div_rem_next;
                n_div_cnt = r_div_cnt - tcw_pkg::DIV_CNT_W'(1);
                if (r_div_cnt == '0) begin
                    n_col      = div_rem_next[tcw_pkg::COL_IDX_W-1:0];
                    n_row_base = r_cursor - AW'(div_rem_next);
                    n_dirty    = 1'b0;
                end
            end
            tcw_pkg::S_READ: begin
                n_res_cursor = r_cursor;
                n_res_char   = r_rdata[tcw_pkg::CHAR_W-1:0];
                n_res_attr   = r_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
            end
            tcw_pkg::S_COPY: begin
                if (r_cp_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wr_addr;
                    mem_wdata = r_rdata;
                end
                if (r_scan < last_row) begin
                    rd_en     = 1'b1;
                    rd_addr   = AW'(r_scan + CW'(eff_cols));
                    n_wr_addr = r_scan[AW-1:0];
                    n_cp_pend = 1'b1;
                    n_scan    = r_scan + CW'(1);
                end else begin
                    n_cp_pend = 1'b0;
                end
            end
            tcw_pkg::S_BLANK: begin
                mem_we    = 1'b1;
                mem_waddr = r_scan[AW-1:0];
                mem_wdata = {attr, tcw_pkg::CH_SPACE};
                n_scan    = r_scan + CW'(1);
            end
            tcw_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_cursor = r_res_cursor;
                    n_out_char   = r_res_char;
                    n_out_attr   = r_res_attr;
                end
            end
            default: ;
        endcase

        if (put_go) begin
            n_res_char = '0;
            n_res_attr = '0;
            n_col      = '0;
            n_scan     = last_row;
            n_cp_pend  = 1'b0;
            if (scroll) begin
                // scrolled cursor lands on the start of the bottom row
                n_scan       = '0;
                n_cursor     = r_row_base;
                n_res_cursor = r_row_base;
                if (!is_nl && !is_cr) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cursor;
                    mem_wdata = {attr, p_char};
                end
            end else if (is_nl) begin
                n_cursor     = nl_next[AW-1:0];
                n_row_base   = nl_next[AW-1:0];
                n_res_cursor = nl_next[AW-1:0];
            end else if (is_cr) begin
                n_cursor     = r_row_base;
                n_res_cursor = r_row_base;
            end else begin
                mem_we       = 1'b1;
                mem_waddr    = r_cursor;
                mem_wdata    = {attr, p_char};
                n_cursor     = inc[AW-1:0];
                n_res_cursor = inc[AW-1:0];
                if (col_inc == eff_cols) begin
                    n_row_base = r_row_base + AW'(eff_cols);
                end else begin
                    n_col = col_inc[tcw_pkg::COL_IDX_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (rd_en)  r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= tcw_pkg::COLS_RESET;
            r_rows    <= tcw_pkg::ROWS_RESET;
            r_fg      <= tcw_pkg::FG_RESET;
            r_bg      <= tcw_pkg::BG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tcw_pkg::REG_COLUMNS:  r_columns <= i_cfg_data[tcw_pkg::COLS_W-1:0];
                tcw_pkg::REG_ROWS:     r_rows    <= i_cfg_data[tcw_pkg::ROWS_W-1:0];
                tcw_pkg::REG_FG_COLOR: r_fg      <= i_cfg_data[tcw_pkg::COLOR_W-1:0];
                tcw_pkg::REG_BG_COLOR: r_bg      <= i_cfg_data[tcw_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::S_CLEAR;
            r_cursor    <= '0;
            r_row_base  <= '0;
            r_col       <= '0;
            r_dirty     <= 1'b0;
            r_scan      <= '0;
            r_cp_pend   <= 1'b0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_row_base  <= n_row_base;
            r_col       <= n_col;
            r_dirty     <= n_dirty;
            r_scan      <= n_scan;
            r_cp_pend   <= n_cp_pend;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr    <= n_wr_addr;
        r_req_char   <= n_req_char;
        r_div_rem    <= n_div_rem;
        r_res_cursor <= n_res_cursor;
        r_res_char   <= n_res_char;
        r_res_attr   <= n_res_attr;
        r_out_cursor <= n_out_cursor;
        r_out_char   <= n_out_char;
        r_out_attr   <= n_out_attr;
    end

endmodule

// ===== sim/text_console_writer_top_tb.sv =====
`timescale 1ns / 1ps

module text_console_writer_top_tb;

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;
    localparam int   N_PHASES = 10;
    localparam int   PHASE_ITEMS = 57;
    localparam int   AW = tcw_pkg::ADDR_W;
    localparam int   DW = tcw_pkg::CFG_DATA_W;
    localparam int   CHW = tcw_pkg::CHAR_W;
    localparam int   ATW = tcw_pkg::ATTR_W;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [AW-1:0]  cursor_position;
        logic [CHW-1:0] cell_char;
        logic [ATW-1:0] cell_attr;
    } t_cons_result;

    typedef struct {
        bit             is_cfg;
        logic           act;
        logic [CHW-1:0] ch;
        logic [AW-1:0]  idx;
        bit             fixed;
        t_cons_result   res;
        logic [DW-1:0]  c_cols, c_rows, c_fg, c_bg;
    } t_stim_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [tcw_pkg::CFG_IDX_W-1:0]  i_cfg_index = tcw_pkg::REG_COLUMNS;
    logic [DW-1:0]                  i_cfg_data = '0;

    tcw_in_if  req_bus ();
    tcw_out_if rsp_bus ();

    text_console_writer_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_bus),
        .o_rsp       (rsp_bus)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [tcw_pkg::CELL_W-1:0]   screen_mem [tcw_pkg::BUF_CELLS];
    int unsigned                  cur_pos;
    logic [tcw_pkg::COLS_W-1:0]   cfg_cols;
    logic [tcw_pkg::ROWS_W-1:0]   cfg_rows;
    logic [tcw_pkg::COLOR_W-1:0]  cfg_fg, cfg_bg;

    t_cons_result          pending_results [$];
    int                    fail_count = 0;
    t_idle_mode            idle_mode = IDLE_NONE;

    // expectation typed into the directed table, travels with the request
    logic                  drv_fixed = 1'b0;
    t_cons_result          drv_fixed_res = '0;

    t_stim_row             directed_rows [$];

    function automatic int unsigned eff_cols();
        if (cfg_cols == 0) return 1;
        if (cfg_cols > tcw_pkg::MAX_COLS) return tcw_pkg::MAX_COLS;
        return 32'(cfg_cols);
    endfunction

    function automatic int unsigned eff_rows();
        if (cfg_rows == 0) return 1;
        if (cfg_rows > tcw_pkg::MAX_ROWS) return tcw_pkg::MAX_ROWS;
        return 32'(cfg_rows);
    endfunction

    function automatic void shift_rows_up(input int unsigned ncols, input int unsigned ncells,
                                          input logic [ATW-1:0] attr);
        for (int unsigned i = 0; i + ncols < ncells; i++)
            screen_mem[i] = screen_mem[i + ncols];
        for (int unsigned i = ncells - ncols; i < ncells; i++)
            screen_mem[i] = {attr, tcw_pkg::CH_SPACE};
        cur_pos = (cur_pos >= ncols) ? cur_pos - ncols : 0;
    endfunction

    function automatic t_cons_result console_step(input logic act, input logic [CHW-1:0] ch,
                                                  input logic [AW-1:0] idx);
        int unsigned    ncols;
        int unsigned    ncells;
        logic [ATW-1:0] attr;
        t_cons_result   r;
        ncols  = eff_cols();
        ncells = ncols * eff_rows();
        attr   = {cfg_bg, cfg_fg};
        r      = '0;
        if (act == ACT_READ) begin
            r.cell_char = screen_mem[idx][CHW-1:0];
            r.cell_attr = screen_mem[idx][tcw_pkg::CELL_W-1:CHW];
        end else begin
            // screen shrank under the cursor: restart on the bottom row
            if (cur_pos >= ncells)
                cur_pos = ncells - ncols;
            if (ch == tcw_pkg::CH_NEWLINE) begin
                cur_pos = (cur_pos / ncols + 1) * ncols;
                if (cur_pos >= ncells)
                    shift_rows_up(ncols, ncells, attr);
            end else if (ch == tcw_pkg::CH_RETURN) begin
                cur_pos = (cur_pos / ncols) * ncols;
            end else begin
                screen_mem[cur_pos] = {attr, ch};
                cur_pos++;
                if (cur_pos >= ncells)
                    shift_rows_up(ncols, ncells, attr);
            end
        end
        r.cursor_position = cur_pos[AW-1:0];
        return r;
    endfunction

    initial begin
        foreach (screen_mem[i])
            screen_mem[i] = '0;
        cur_pos  = 0;
        cfg_cols = tcw_pkg::COLS_RESET;
        cfg_rows = tcw_pkg::ROWS_RESET;
        cfg_fg   = tcw_pkg::FG_RESET;
        cfg_bg   = tcw_pkg::BG_RESET;
    end

    // monitor: predict on each accepted request, check each accepted result
    always @(posedge i_clk) begin
        t_cons_result pred;
        t_cons_result want;
        t_cons_result got;
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready) begin
                pred = console_step(req_bus.action, req_bus.char_code, req_bus.cell_index);
                pending_results.push_back(drv_fixed ? drv_fixed_res : pred);
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
                got.cursor_position = rsp_bus.cursor_position;
                got.cell_char       = rsp_bus.cell_char;
                got.cell_attr       = rsp_bus.cell_attr;
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding: cursor_position %0d",
                           got.cursor_position);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.cursor_position !== want.cursor_position) begin
                        $error("cursor_position: expected %0d, got %0d",
                               want.cursor_position, got.cursor_position);
                        fail_count++;
                    end
                    if (got.cell_char !== want.cell_char) begin
                        $error("cell_char: expected 0x%02h, got 0x%02h",
                               want.cell_char, got.cell_char);
                        fail_count++;
                    end
                    if (got.cell_attr !== want.cell_attr) begin
                        $error("cell_attr: expected 0x%02h, got 0x%02h",
                               want.cell_attr, got.cell_attr);
                        fail_count++;
                    end
                end
            end
        end
    end

    // result side back-pressure
    initial rsp_bus.ready = 1'b0;
    always @(negedge i_clk) begin
        case (idle_mode)
            IDLE_RECV: rsp_bus.ready <= ($urandom_range(0, 99) >= 82);
            IDLE_BOTH: rsp_bus.ready <= ($urandom_range(0, 99) >= 32);
            default:   rsp_bus.ready <= 1'b1;
        endcase
    end

    function automatic bit send_gap();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(0, 99) < 82;
            IDLE_BOTH: return $urandom_range(0, 99) < 32;
            default:   return 1'b0;
        endcase
    endfunction

    // all tasks below are entered and left at a falling edge
    task automatic send_request(input logic act, input logic [CHW-1:0] ch,
                                input logic [AW-1:0] idx, input bit fixed,
                                input t_cons_result fres, input bit drain_first);
        if (drain_first) begin
            req_bus.valid <= 1'b0;
            do @(negedge i_clk); while (pending_results.size() != 0);
        end
        while (send_gap()) begin
            req_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.action     <= act;
        req_bus.char_code  <= ch;
        req_bus.cell_index <= idx;
        drv_fixed          <= fixed;
        drv_fixed_res      <= fres;
        do @(posedge i_clk); while (!req_bus.ready);
        @(negedge i_clk);
    endtask

    task automatic settle();
        req_bus.valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic put_reg(input tcw_pkg::t_cfg_reg r, input logic [DW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= data;
        case (r)
            tcw_pkg::REG_COLUMNS:  cfg_cols = data[tcw_pkg::COLS_W-1:0];
            tcw_pkg::REG_ROWS:     cfg_rows = data[tcw_pkg::ROWS_W-1:0];
            tcw_pkg::REG_FG_COLOR: cfg_fg   = data[tcw_pkg::COLOR_W-1:0];
            tcw_pkg::REG_BG_COLOR: cfg_bg   = data[tcw_pkg::COLOR_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic program_config(input logic [DW-1:0] cols, input logic [DW-1:0] rws,
                                  input logic [DW-1:0] fg, input logic [DW-1:0] bg);
        put_reg(tcw_pkg::REG_COLUMNS, cols);
        put_reg(tcw_pkg::REG_ROWS, rws);
        put_reg(tcw_pkg::REG_FG_COLOR, fg);
        put_reg(tcw_pkg::REG_BG_COLOR, bg);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic void add_item(input logic act, input logic [CHW-1:0] ch,
                                     input logic [AW-1:0] idx, input bit fixed,
                                     input int cpos, input int cch, input int cattr);
        t_stim_row row;
        row = '{default: '0};
        row.act = act;
        row.ch  = ch;
        row.idx = idx;
        row.fixed = fixed;
        row.res = '{cpos[AW-1:0], cch[CHW-1:0], cattr[ATW-1:0]};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input int cols, input int rws, input int fg, input int bg);
        t_stim_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.c_cols = cols[DW-1:0];
        row.c_rows = rws[DW-1:0];
        row.c_fg   = fg[DW-1:0];
        row.c_bg   = bg[DW-1:0];
        directed_rows.push_back(row);
    endfunction

    initial begin
        logic           act;
        logic [CHW-1:0] ch;
        logic [AW-1:0]  idx;
        int unsigned    sel;
        logic [DW-1:0]  ncols, nrows;
        t_idle_mode     mode;

        req_bus.valid      = 1'b0;
        req_bus.action     = ACT_PUT;
        req_bus.char_code  = '0;
        req_bus.cell_index = '0;

        // after reset: 80 x 25, white on black
        add_item(ACT_READ, 8'h00, 13'd0,    1, 0, 8'h00, 8'h00);
        add_item(ACT_READ, 8'h00, 13'h1FFF, 1, 0, 8'h00, 8'h00);
        add_item(ACT_PUT,  8'h41, 13'd0,    1, 1, 8'h00, 8'h00);
        add_item(ACT_READ, 8'h00, 13'd0,    1, 1, 8'h41, 8'h0F);
        add_item(ACT_PUT,  tcw_pkg::CH_NEWLINE, 13'd0, 1, 80, 8'h00, 8'h00);
        add_item(ACT_PUT,  tcw_pkg::CH_RETURN,  13'd0, 1, 80, 8'h00, 8'h00);
        add_item(ACT_PUT,  8'h00, 13'h1FFF, 1, 81, 8'h00, 8'h00);
        add_item(ACT_PUT,  8'hFF, 13'd0,    1, 82, 8'h00, 8'h00);
        add_item(ACT_READ, 8'hFF, 13'd80,   1, 82, 8'h00, 8'h0F);
        add_item(ACT_READ, 8'h00, 13'd81,   1, 82, 8'hFF, 8'h0F);
        add_item(ACT_READ, 8'hFF, 13'h1555, 0, 0, 0, 0);
        add_item(ACT_READ, 8'h00, 13'h0AAA, 0, 0, 0, 0);
        // shrink under the cursor, then scroll a two-row screen
        add_cfg(4, 2, 0, 15);
        add_item(ACT_PUT,  8'h78, 13'd0, 0, 0, 0, 0);
        add_item(ACT_PUT,  tcw_pkg::CH_NEWLINE, 13'd0, 0, 0, 0, 0);
        add_item(ACT_READ, 8'h00, 13'd0, 0, 0, 0, 0);
        add_item(ACT_READ, 8'h00, 13'd4, 0, 0, 0, 0);
        // zero sizes read as a single cell: every put but a carriage return scrolls
        add_cfg(0, 0, 5, 10);
        add_item(ACT_PUT,  8'h61, 13'd0, 0, 0, 0, 0);
        add_item(ACT_PUT,  tcw_pkg::CH_RETURN,  13'd0, 0, 0, 0, 0);
        add_item(ACT_PUT,  tcw_pkg::CH_NEWLINE, 13'd0, 0, 0, 0, 0);
        add_item(ACT_READ, 8'h00, 13'd0, 0, 0, 0, 0);
        // sizes past the maximum clamp to 128 x 64
        add_cfg(255, 127, 15, 15);
        add_item(ACT_PUT,  8'h7E, 13'd0, 0, 0, 0, 0);
        add_item(ACT_PUT,  tcw_pkg::CH_NEWLINE, 13'd0, 0, 0, 0, 0);
        add_item(ACT_READ, 8'h00, 13'h1FFF, 0, 0, 0, 0);
        // single full-width row: scroll only blanks it
        add_cfg(128, 1, 0, 0);
        add_item(ACT_PUT,  tcw_pkg::CH_NEWLINE, 13'd0, 0, 0, 0, 0);
        add_item(ACT_READ, 8'h00, 13'd0, 0, 0, 0, 0);
        add_item(ACT_READ, 8'h00, 13'd127, 0, 0, 0, 0);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                settle();
                program_config(directed_rows[i].c_cols, directed_rows[i].c_rows,
                               directed_rows[i].c_fg, directed_rows[i].c_bg);
            end else begin
                send_request(directed_rows[i].act, directed_rows[i].ch, directed_rows[i].idx,
                             directed_rows[i].fixed, directed_rows[i].res, 1'b0);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            mode = t_idle_mode'(p % 4);
            idle_mode <= mode;
            case (p)
                2: begin
                    ncols = DW'($urandom_range(128, 255));
                    nrows = DW'($urandom_range(64, 127));
                end
                5: begin
                    ncols = DW'(1);
                    nrows = DW'(64);
                end
                7: begin
                    ncols = DW'($urandom_range(129, 255));
                    nrows = DW'(1);
                end
                default: begin
                    ncols = DW'($urandom_range(0, 12));
                    nrows = DW'($urandom_range(0, 6));
                end
            endcase
            program_config(ncols, nrows, DW'($urandom_range(0, 255)),
                           DW'($urandom_range(0, 255)));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                sel = $urandom_range(0, 99);
                ch  = CHW'($urandom_range(0, 255));
                idx = AW'($urandom_range(0, tcw_pkg::BUF_CELLS - 1));
                if (sel < 30) begin
                    act = ACT_READ;
                    if ($urandom_range(0, 1) == 0)
                        idx = AW'($urandom_range(0, eff_cols() * eff_rows() - 1));
                end else begin
                    act = ACT_PUT;
                    if (sel < 45)
                        ch = tcw_pkg::CH_NEWLINE;
                    else if (sel < 55)
                        ch = tcw_pkg::CH_RETURN;
                end
                send_request(act, ch, idx, 1'b0, '0,
                             mode == IDLE_SEND && (k == 20 || $urandom_range(0, 24) == 0));
            end
        end

        settle();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("text_console_writer_top_tb OK");
        else
            $display("text_console_writer_top_tb NOT OK");
        $finish;
    end

    initial begin
        #100ms;
        $display("text_console_writer_top_tb NOT OK");
        $finish;
    end

endmodule

// ===== text_console_writer_top.f =====
rtl/tcw_pkg.sv
rtl/tcw_in_if.sv
rtl/tcw_out_if.sv
rtl/text_console_writer_top.sv
sim/text_console_writer_top_tb.sv
